// ===== design/lsie_pkg.sv =====
// ---------------------------------------------------------------------------
// lsie_pkg: shared definitions for the instruction executor
// Instruction categories, opcodes, alu operation codes, microcode step
// codes, the control word layout and the microcode rom.
// ---------------------------------------------------------------------------
package lsie_pkg;

  // instruction categories, bits 31:29
  localparam logic [2:0] CAT_CB  = 3'b001;
  localparam logic [2:0] CAT_ALI = 3'b010;
  localparam logic [2:0] CAT_ALR = 3'b011;
  localparam logic [2:0] CAT_MEM = 3'b100;

  // opcodes
  localparam logic [4:0] OP_CBZ  = 5'b10000;
  localparam logic [6:0] OP_ORRI = 7'b1000000;
  localparam logic [6:0] OP_EORI = 7'b1000001;
  localparam logic [6:0] OP_ADDI = 7'b1000010;
  localparam logic [6:0] OP_SUBI = 7'b1000011;
  localparam logic [7:0] OP_EOR  = 8'b10100000;
  localparam logic [7:0] OP_ADD  = 8'b10100010;
  localparam logic [7:0] OP_SUB  = 8'b10100011;
  localparam logic [7:0] OP_AND  = 8'b10100100;
  localparam logic [7:0] OP_ORR  = 8'b10100101;
  localparam logic [7:0] OP_LSR  = 8'b10100110;
  localparam logic [7:0] OP_LDUR = 8'b10101010;

  // alu operations
  typedef logic [2:0] alu_op_t;
  localparam alu_op_t ALU_AND = 3'd0;
  localparam alu_op_t ALU_OR  = 3'd1;
  localparam alu_op_t ALU_XOR = 3'd2;
  localparam alu_op_t ALU_ADD = 3'd3;
  localparam alu_op_t ALU_SUB = 3'd4;
  localparam alu_op_t ALU_LSR = 3'd5;
  localparam alu_op_t ALU_LSL = 3'd6;

  // microcode step codes
  typedef logic [3:0] step_t;
  localparam step_t ST_FETCH  = 4'd0;
  localparam step_t ST_PRE    = 4'd1;
  localparam step_t ST_CB_RD  = 4'd2;
  localparam step_t ST_CB_EX  = 4'd3;
  localparam step_t ST_AI_RD  = 4'd4;
  localparam step_t ST_ALU    = 4'd5;
  localparam step_t ST_WB     = 4'd6;
  localparam step_t ST_AR_RD  = 4'd7;
  localparam step_t ST_M_RD   = 4'd8;
  localparam step_t ST_M_AG   = 4'd9;
  localparam step_t ST_M_CHK  = 4'd10;
  localparam step_t ST_M_ACC  = 4'd11;
  localparam step_t ST_M_LD   = 4'd12;
  localparam step_t ST_ADV    = 4'd13;

  // one microcode control word
  typedef struct packed {
    logic  pre;      // preload write to data memory
    logic  br;       // compare and branch, updates pc
    logic  ex;       // capture alu result
    logic  agen;     // base plus offset
    logic  dchk;     // distance from data base, range check
    logic  mem_acc;  // store write when in range
    logic  wb;       // register file write
    logic  wb_mem;   // write-back data from memory
    logic  pc4;      // pc advances by four
    logic  done;     // result beat leaves this step
    logic  jc;       // jump when fault or not a load
    step_t jt;       // jump target
    step_t nxt;      // next step
  } ucw_t;

  // microcode rom
  function automatic ucw_t ucode(input step_t s);
    ucw_t cw;
    cw = '0;
    case (s)
      ST_PRE:   begin cw.pre = 1'b1; cw.done = 1'b1; end
      ST_CB_RD: cw.nxt = ST_CB_EX;
      ST_CB_EX: begin cw.br = 1'b1; cw.done = 1'b1; end
      ST_AI_RD: cw.nxt = ST_ALU;
      ST_AR_RD: cw.nxt = ST_ALU;
      ST_ALU:   begin cw.ex = 1'b1; cw.nxt = ST_WB; end
      ST_WB:    begin cw.wb = 1'b1; cw.pc4 = 1'b1; cw.done = 1'b1; end
      ST_M_RD:  cw.nxt = ST_M_AG;
      ST_M_AG:  begin cw.agen = 1'b1; cw.nxt = ST_M_CHK; end
      ST_M_CHK: begin cw.dchk = 1'b1; cw.nxt = ST_M_ACC; end
      ST_M_ACC: begin
        cw.mem_acc = 1'b1;
        cw.jc = 1'b1;
        cw.jt = ST_ADV;
        cw.nxt = ST_M_LD;
      end
      ST_M_LD:  begin
        cw.wb = 1'b1; cw.wb_mem = 1'b1; cw.pc4 = 1'b1; cw.done = 1'b1;
      end
      ST_ADV:   begin cw.pc4 = 1'b1; cw.done = 1'b1; end
      default:  cw = '0;
    endcase
    return cw;
  endfunction

  // alu operation for register/immediate and register/register categories
  function automatic alu_op_t alu_decode(input logic [31:0] instr);
    alu_op_t op;
    op = ALU_AND;
    if (instr[31:29] == CAT_ALI) begin
      unique case (instr[28:22])
        OP_ORRI: op = ALU_OR;
        OP_EORI: op = ALU_XOR;
        OP_ADDI: op = ALU_ADD;
        OP_SUBI: op = ALU_SUB;
        default: op = ALU_AND;
      endcase
    end else begin
      unique case (instr[28:21])
        OP_EOR:  op = ALU_XOR;
        OP_ADD:  op = ALU_ADD;
        OP_SUB:  op = ALU_SUB;
        OP_AND:  op = ALU_AND;
        OP_ORR:  op = ALU_OR;
        OP_LSR:  op = ALU_LSR;
        default: op = ALU_LSL;
      endcase
    end
    return op;
  endfunction

endpackage

// ===== design/lsie_alu.sv =====
// ---------------------------------------------------------------------------
// lsie_alu: 32-bit integer alu
// Logic, add, subtract and logical shifts by the low five bits of b.
// ---------------------------------------------------------------------------
module lsie_alu (
  input  lsie_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       y
);
  import lsie_pkg::*;

  // operation select
  always_comb begin
    unique case (op)
      ALU_AND: y = a & b;
      ALU_OR:  y = a | b;
      ALU_XOR: y = a ^ b;
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      ALU_LSR: y = a >> b[4:0];
      ALU_LSL: y = a << b[4:0];
      default: y = a & b;
    endcase
  end

endmodule

// ===== design/legv8_subset_instruction_executor.sv =====
// ---------------------------------------------------------------------------
// legv8_subset_instruction_executor: microcoded instruction executor
// Runs one instruction word or one data memory preload per input beat.
// ---------------------------------------------------------------------------
// Each kind of item (preload, no-op, branch, alu, load or store) runs its own
// microcode program from the input beat to the result beat being offered.
// One item is in flight; the next beat is taken while the result register
// still waits. Reset sets pc to RESET_PC, reads of the register file as zero
// (per-register valid bits) and data_base to zero; data memory is undefined
// until written and has no clearing pass.
module legv8_subset_instruction_executor #(
  parameter int          MEM_WORDS = 256,
  parameter logic [31:0] RESET_PC  = 32'd64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_base_we,
  input  logic [31:0] data_base_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: instr[31:0], preload_index[39:32], preload_value[71:40]
  input  logic [71:0] s_axis_tdata,
  // tuser: func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: next_pc[31:0], branch_taken[32], reg_written[33], reg_index[38:34],
  //        reg_value[70:39], mem_fault[71], not_recognized[72], zero[79:73]
  output logic [79:0] m_axis_tdata
);
  import lsie_pkg::*;

  localparam int          IDXW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [32:0] MEM_WORDS_W = 33'(MEM_WORDS);

  // item registers
  logic [31:0] instr;
  logic [7:0]  pidx;
  logic [31:0] pval;
  logic [31:0] data_base;
  logic [31:0] pc;

  // datapath registers
  logic [31:0]     a_q;
  logic [31:0]     b_q;
  logic [31:0]     res;
  logic [33:0]     addr;
  logic [IDXW-1:0] mem_idx;
  logic [31:0]     mem_q;

  // result flags
  logic        taken, written, fault, unknown;
  logic [4:0]  ridx;
  logic [31:0] rval;
  logic [31:0] pc_next, rval_next;
  logic        taken_next, written_next, fault_next, unknown_next;
  logic [4:0]  ridx_next;

  // sequencer
  step_t upc, upc_next;
  ucw_t  cw;
  logic  accept, stall, go, is_load;

  // storage
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld;
  logic [31:0] data_mem [MEM_WORDS];

  logic [4:0]      ra, rb, rf_wa;
  logic            rf_we;
  logic [31:0]     rf_wd;
  logic            mem_we;
  logic [IDXW-1:0] mem_wa;
  logic [31:0]     mem_wd;
  logic [31:0]     alu_b, alu_y;
  logic [34:0]     span;
  logic [32:0]     pre_wide;
  logic            pre_ok;

  assign cw            = ucode(upc);
  assign s_axis_tready = (upc == ST_FETCH) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign stall         = cw.done && m_axis_tvalid && !m_axis_tready;
  assign go            = (upc != ST_FETCH) && !stall;
  assign is_load       = (instr[28:21] == OP_LDUR);

  // sequencer: dispatch on the input beat, then step through the rom
  always_comb begin
    upc_next = upc;
    if (accept) begin
      if (s_axis_tuser) begin
        upc_next = ST_PRE;
      end else begin
        case (s_axis_tdata[31:29])
          CAT_CB:  upc_next = ST_CB_RD;
          CAT_ALI: upc_next = ST_AI_RD;
          CAT_ALR: upc_next = ST_AR_RD;
          CAT_MEM: upc_next = ST_M_RD;
          default: upc_next = ST_ADV;
        endcase
      end
    end else if (go) begin
      if (cw.done) begin
        upc_next = ST_FETCH;
      end else if (cw.jc && (fault || !is_load)) begin
        upc_next = cw.jt;
      end else begin
        upc_next = cw.nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      data_base <= '0;
    end else if (data_base_we) begin
      data_base <= data_base_wdata;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      instr <= s_axis_tdata[31:0];
      pidx  <= s_axis_tdata[39:32];
      pval  <= s_axis_tdata[71:40];
    end
  end

  // register file read ports, chosen by category
  always_comb begin
    ra = instr[15:11];
    rb = instr[10:6];
    case (instr[31:29])
      CAT_CB:  ra = instr[23:19];
      CAT_ALI: ra = instr[16:12];
      CAT_MEM: rb = instr[20:16];
      default: ra = instr[15:11];
    endcase
  end

  assign rf_wa = (instr[31:29] == CAT_ALI) ? instr[21:17] : instr[20:16];
  assign rf_we = go && cw.wb;
  assign rf_wd = cw.wb_mem ? mem_q : res;

  // register file: one write, two registered reads
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    a_q <= rf_vld[ra] ? rf_mem[ra] : '0;
    b_q <= rf_vld[rb] ? rf_mem[rb] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_we) begin
      rf_vld[rf_wa] <= 1'b1;
    end
  end

  // alu
  assign alu_b = (instr[31:29] == CAT_ALI) ? {{20{instr[11]}}, instr[11:0]} : b_q;

  lsie_alu u_alu (
    .op (alu_decode(instr)),
    .a  (a_q),
    .b  (alu_b),
    .y  (alu_y)
  );

  // address path
  assign span     = {addr[33], addr} - {3'b000, data_base};
  assign pre_wide = {25'b0, pidx};
  assign pre_ok   = pre_wide < MEM_WORDS_W;

  always_ff @(posedge clk) begin
    if (go && cw.ex) begin
      res <= alu_y;
    end
    if (go && cw.agen) begin
      addr <= {{2{a_q[31]}}, a_q} + {{23{instr[10]}}, instr[10:0]};
    end
    if (go && cw.dchk) begin
      mem_idx <= span[IDXW+1:2];
    end
  end

  // data memory: one write port, registered read
  assign mem_we = go && ((cw.pre && pre_ok) || (cw.mem_acc && !fault && !is_load));
  assign mem_wa = cw.pre ? pre_wide[IDXW-1:0] : mem_idx;
  assign mem_wd = cw.pre ? pval : b_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      data_mem[mem_wa] <= mem_wd;
    end
    mem_q <= data_mem[mem_idx];
  end

  // result fields for this step
  always_comb begin
    pc_next      = pc;
    taken_next   = taken;
    written_next = written;
    ridx_next    = ridx;
    rval_next    = rval;
    fault_next   = fault;
    unknown_next = unknown;
    if (accept) begin
      taken_next   = 1'b0;
      written_next = 1'b0;
      ridx_next    = '0;
      rval_next    = '0;
      fault_next   = 1'b0;
      unknown_next = !s_axis_tuser && (s_axis_tdata[31:29] != CAT_CB)
                     && (s_axis_tdata[31:29] != CAT_ALI)
                     && (s_axis_tdata[31:29] != CAT_ALR)
                     && (s_axis_tdata[31:29] != CAT_MEM);
    end else if (go) begin
      if (cw.pre && !pre_ok) begin
        fault_next = 1'b1;
      end
      if (cw.dchk) begin
        fault_next = span[34] || (span[34:2] >= MEM_WORDS_W);
      end
      if (cw.br) begin
        if ((instr[28:24] == OP_CBZ) ? (a_q == '0) : (a_q != '0)) begin
          pc_next    = pc + {{11{instr[18]}}, instr[18:0], 2'b00};
          taken_next = 1'b1;
        end else begin
          pc_next = pc + 32'd4;
        end
      end
      if (cw.pc4) begin
        pc_next = pc + 32'd4;
      end
      if (cw.wb) begin
        written_next = 1'b1;
        ridx_next    = rf_wa;
        rval_next    = rf_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= RESET_PC;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    taken   <= taken_next;
    written <= written_next;
    ridx    <= ridx_next;
    rval    <= rval_next;
    fault   <= fault_next;
    unknown <= unknown_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (go && cw.done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && cw.done) begin
      m_axis_tdata <= {7'b0, unknown_next, fault_next, rval_next, ridx_next,
                       written_next, taken_next, pc_next};
    end
  end

  // an accepted beat closes the input until the program finishes
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // pc only moves when a result beat is produced
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(pc))
    else $error("pc changed while a result was held");

  // register writes are always reported
  a_wb_flag: assert property (@(posedge clk) disable iff (rst)
    rf_we |=> written)
    else $error("register write without write flag");

  // a faulting access never writes a register
  a_fault_wb: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[71] && m_axis_tdata[33]))
    else $error("fault and write-back reported together");

endmodule
